>>> sv/tbp_pkg.sv
// Shared types and constants of the per-client token bucket policer.
// No dependencies; every other file of the block refers to this package.

package tbp_pkg;

    // Fixed-point format of bucket levels and the refill rate
    localparam int FRAC_BITS = 16;
    localparam logic [31:0] ONE_FX = 32'd1 << FRAC_BITS;

    // Number of distinct client indexes the 8-bit field can carry
    localparam int CLIENT_SPAN = 256;
    localparam int NUM_CLIENTS_DEF = 256;

    // Register map: index taken from paddr[2]
    localparam int APB_ADDR_W = 3;
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_REFILL = 1'b1;

    localparam logic [15:0] CAPACITY_RESET = 16'd10;
    localparam logic [31:0] REFILL_RESET = 32'd65536;

    // Request transfer
    typedef struct packed {
        logic [7:0]  client_index;
        logic [31:0] time_stamp;
    } req_t;

    // Result transfer
    typedef struct packed {
        logic        allowed;
        logic [7:0]  client_echo;
        logic [31:0] tokens_left;
    } resp_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [15:0] capacity_tokens;
        logic [31:0] refill_per_tick;
    } cfg_t;

    // One bucket record: level and time mark
    typedef struct packed {
        logic [31:0] level;
        logic [31:0] mark;
    } bucket_t;

endpackage

>>> sv/tbp_apb_regs.sv
// APB configuration registers of the token bucket policer.
// Depends on tbp_pkg.

module tbp_apb_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output tbp_pkg::cfg_t                  cfg
);

    logic [15:0] capacity_reg;
    logic [31:0] refill_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= tbp_pkg::CAPACITY_RESET;
            refill_reg   <= tbp_pkg::REFILL_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                tbp_pkg::REG_CAPACITY: capacity_reg <= pwdata[15:0];
                tbp_pkg::REG_REFILL:   refill_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        case (paddr[2])
            tbp_pkg::REG_CAPACITY: prdata = {16'd0, capacity_reg};
            tbp_pkg::REG_REFILL:   prdata = refill_reg;
            default:               prdata = 32'd0;
        endcase
    end

    assign cfg.capacity_tokens = capacity_reg;
    assign cfg.refill_per_tick = refill_reg;

endmodule

>>> sv/tbp_state_ram.sv
// Bucket state memory: one level and one time mark per client slot.
// Single write port, single read port with registered read data. Depends on tbp_pkg.

module tbp_state_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output tbp_pkg::bucket_t    rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  tbp_pkg::bucket_t    wr_data
);

    tbp_pkg::bucket_t mem [DEPTH];
    tbp_pkg::bucket_t rd_data_reg;

    // Write port; contents are undefined until a slot is first written
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; returns old data on a same-edge write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/tbp_refill_calc.sv
// Refill and admission decision for one request against one bucket record.
// Purely combinational; depends on tbp_pkg.

module tbp_refill_calc (
    input  tbp_pkg::cfg_t    cfg,
    input  logic             seen,
    input  tbp_pkg::bucket_t stored,
    input  logic [31:0]      time_stamp,
    output tbp_pkg::bucket_t updated,
    output logic             allowed
);

    logic [47:0] cap_shift;
    logic [31:0] cap_fx;
    logic [31:0] base_level;
    logic [31:0] base_mark;
    logic [31:0] elapsed;
    logic [63:0] product;
    logic [31:0] refill;
    logic [32:0] sum;
    logic [31:0] capped;
    logic [31:0] level;

    // Capacity in fixed point, saturated to 32 bits
    assign cap_shift = 48'(cfg.capacity_tokens) << tbp_pkg::FRAC_BITS;
    assign cap_fx    = (|cap_shift[47:32]) ? 32'hFFFF_FFFF : cap_shift[31:0];

    // A new client starts full, marked now
    assign base_level = seen ? stored.level : cap_fx;
    assign base_mark  = seen ? stored.mark  : time_stamp;

    // Refill = elapsed ticks times rate, saturated
    assign elapsed = time_stamp - base_mark;
    assign product = 64'(elapsed) * 64'(cfg.refill_per_tick);
    assign refill  = (|product[63:32]) ? 32'hFFFF_FFFF : product[31:0];

    // Add and clamp to capacity
    assign sum    = {1'b0, base_level} + {1'b0, refill};
    assign capped = (sum < {1'b0, cap_fx}) ? sum[31:0] : cap_fx;

    always_comb begin
        if (refill != 32'd0) begin
            level        = capped;
            updated.mark = time_stamp;
        end else begin
            level        = base_level;
            updated.mark = base_mark;
        end
        // Spend one whole token if there is one
        allowed = (level >= tbp_pkg::ONE_FX);
        updated.level = allowed ? (level - tbp_pkg::ONE_FX) : level;
    end

endmodule

>>> sv/per_client_token_bucket_policer.sv
// Per-client token bucket policer. A request passes through the state memory read,
// then the decision goes into the output register.
// Throughput: one request per cycle unless the output stalls; the last state write
// is forwarded to the next read, so back-to-back requests for one client proceed at
// full rate. Reset (aresetn, synchronous): clears handshake state and all seen flags
// and restores the configuration defaults; the state memory itself is not cleared.

module per_client_token_bucket_policer #(
    parameter int NUM_CLIENTS = tbp_pkg::NUM_CLIENTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tbp_pkg::req_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tbp_pkg::resp_t                 m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // Only indexes reachable from the 8-bit field need storage
    localparam int DEPTH  = (NUM_CLIENTS < tbp_pkg::CLIENT_SPAN) ? NUM_CLIENTS
                                                                 : tbp_pkg::CLIENT_SPAN;
    localparam int SLOT_W = $clog2(DEPTH);

    tbp_pkg::cfg_t    cfg;
    tbp_pkg::bucket_t ram_rd_data;
    tbp_pkg::bucket_t stored;
    tbp_pkg::bucket_t updated;
    logic             allowed;
    logic             in_xfer;
    logic             advance;
    logic             seen;
    logic             fwd_hit;

    logic [SLOT_W-1:0] slot_lut [tbp_pkg::CLIENT_SPAN];
    logic [SLOT_W-1:0] in_slot;

    logic              st1_valid_reg, st1_valid_next;
    tbp_pkg::req_t     st1_req_reg;
    logic [SLOT_W-1:0] st1_slot_reg;
    logic              out_valid_reg, out_valid_next;
    tbp_pkg::resp_t    out_reg;
    logic [DEPTH-1:0]  seen_reg;
    logic              wr_valid_reg;
    logic [SLOT_W-1:0] wr_slot_reg;
    tbp_pkg::bucket_t  wr_data_reg;

    // Client index modulo NUM_CLIENTS, as a constant lookup table
    for (genvar c = 0; c < tbp_pkg::CLIENT_SPAN; c++) begin : g_slot_lut
        assign slot_lut[c] = SLOT_W'(c % NUM_CLIENTS);
    end
    assign in_slot = slot_lut[s_data.client_index];

    tbp_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake control
    assign advance        = st1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !st1_valid_reg || advance;
    assign in_xfer        = s_valid && s_ready;
    assign st1_valid_next = in_xfer || (st1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    tbp_state_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (in_xfer),
        .rd_addr (in_slot),
        .rd_data (ram_rd_data),
        .wr_en   (advance),
        .wr_addr (st1_slot_reg),
        .wr_data (updated)
    );

    // Latest write always mirrors the memory, so it can stand in for a stale read
    assign fwd_hit = wr_valid_reg && (wr_slot_reg == st1_slot_reg);
    assign stored  = fwd_hit ? wr_data_reg : ram_rd_data;
    assign seen    = seen_reg[st1_slot_reg];

    tbp_refill_calc u_calc (
        .cfg        (cfg),
        .seen       (seen),
        .stored     (stored),
        .time_stamp (st1_req_reg.time_stamp),
        .updated    (updated),
        .allowed    (allowed)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            seen_reg      <= '0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                wr_valid_reg           <= 1'b1;
                seen_reg[st1_slot_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            st1_req_reg  <= s_data;
            st1_slot_reg <= in_slot;
        end
        if (advance) begin
            wr_slot_reg         <= st1_slot_reg;
            wr_data_reg         <= updated;
            out_reg.allowed     <= allowed;
            out_reg.client_echo <= st1_req_reg.client_index;
            out_reg.tokens_left <= updated.level;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> sv/tbp_checker.sv
// Port-level checks for the token bucket policer, bound to the top level.
// Depends on tbp_pkg and per_client_token_bucket_policer.

module tbp_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input tbp_pkg::req_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input tbp_pkg::resp_t m_data
);

    // Result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // A limited request leaves less than one whole token
    a_limited_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.allowed |-> m_data.tokens_left < tbp_pkg::ONE_FX)
        else $error("limited request with a whole token left");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Unstalled request passes the stage-one registers, then reaches the output register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("result missing after request transfer");

endmodule

bind per_client_token_bucket_policer tbp_checker u_tbp_checker (.*);
